// ===== hdl/sbsh_pkg.sv =====
// shared types and constants for the segment versus widened box hit test
// no dependencies; used by sbsh_axis_prep and segment_box_slab_hit_test_core
`default_nettype none

package sbsh_pkg;

	// configuration register layout
	localparam int HW_BITS = 12;
	localparam logic REG_HALF_WIDTH = 1'b0;

	// per-axis status handed from the axis front end to the core
	typedef struct packed {
		logic moving;   // start and end differ on this axis
		logic in_slab;  // start lies in the widened slab, bounds included
	} sbsh_axis_flags_t;

endpackage

`default_nettype wire

// ===== hdl/sbsh_axis_prep.sv =====
// axis front end: widens one slab and forms the slab numerators and denominator
// depends on sbsh_pkg; two register stages, no handshake of its own
`default_nettype none

module sbsh_axis_prep
	import sbsh_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire                                   clk,
	input  wire  signed [COORD_BITS-1:0]          seg_start,
	input  wire  signed [COORD_BITS-1:0]          seg_end,
	input  wire  signed [COORD_BITS-1:0]          box_min,
	input  wire  signed [COORD_BITS-1:0]          box_max,
	input  wire         [HW_BITS-1:0]             half_width,
	output logic signed [((COORD_BITS > 13) ? COORD_BITS : 13) + 1:0] n_lo,
	output logic signed [((COORD_BITS > 13) ? COORD_BITS : 13) + 1:0] n_hi,
	output logic        [COORD_BITS-1:0]          denom,
	output sbsh_axis_flags_t                      flags
);

	// bound width after widening, numerator width after subtracting the start
	localparam int BW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
	localparam int NW = BW + 1;

	logic signed [BW-1:0]         org_w;
	logic signed [BW-1:0]         min_w;
	logic signed [BW-1:0]         max_w;
	logic signed [BW-1:0]         hw_w;
	logic signed [COORD_BITS:0]   dlt_c;

	logic signed [BW-1:0]         org_s1;
	logic signed [BW-1:0]         lo_s1;
	logic signed [BW-1:0]         hi_s1;
	logic signed [COORD_BITS:0]   dlt_s1;

	logic                         neg_c;
	logic signed [NW-1:0]         org_n;
	logic signed [NW-1:0]         lo_n;
	logic signed [NW-1:0]         hi_n;
	logic        [COORD_BITS:0]   mag_c;

	logic signed [NW-1:0]         n_lo_s2;
	logic signed [NW-1:0]         n_hi_s2;
	logic        [COORD_BITS-1:0] denom_s2;
	sbsh_axis_flags_t             flags_s2;

	// stage 1: widen the bounds, take the segment delta
	assign org_w = {{(BW-COORD_BITS){seg_start[COORD_BITS-1]}}, seg_start};
	assign min_w = {{(BW-COORD_BITS){box_min[COORD_BITS-1]}}, box_min};
	assign max_w = {{(BW-COORD_BITS){box_max[COORD_BITS-1]}}, box_max};
	assign hw_w  = {{(BW-HW_BITS){1'b0}}, half_width};
	assign dlt_c = {seg_end[COORD_BITS-1], seg_end} - {seg_start[COORD_BITS-1], seg_start};

	always_ff @(posedge clk) begin
		org_s1 <= org_w;
		lo_s1  <= min_w - hw_w;
		hi_s1  <= max_w + hw_w;
		dlt_s1 <= dlt_c;
	end

	// stage 2: numerators with the delta sign folded in, delta magnitude
	assign neg_c = dlt_s1[COORD_BITS];
	assign org_n = {org_s1[BW-1], org_s1};
	assign lo_n  = {lo_s1[BW-1], lo_s1};
	assign hi_n  = {hi_s1[BW-1], hi_s1};
	assign mag_c = neg_c ? (-dlt_s1) : dlt_s1;

	always_ff @(posedge clk) begin
		n_lo_s2          <= neg_c ? (org_n - lo_n) : (lo_n - org_n);
		n_hi_s2          <= neg_c ? (org_n - hi_n) : (hi_n - org_n);
		denom_s2         <= mag_c[COORD_BITS-1:0];
		flags_s2.moving  <= (dlt_s1 != '0);
		flags_s2.in_slab <= !((org_s1 < lo_s1) || (org_s1 > hi_s1));
	end

	assign n_lo  = n_lo_s2;
	assign n_hi  = n_hi_s2;
	assign denom = denom_s2;
	assign flags = flags_s2;

endmodule

`default_nettype wire

// ===== hdl/segment_box_slab_hit_test_core.sv =====
// segment versus widened axis-aligned box hit test, slab method, exact fractions
// done is the valid bit carried with each accepted beat through the pipeline stages
// throughput: a new item every cycle, every stage takes a beat per cycle; busy stays low
// the receiver cannot stall, each result shows on hit/done for exactly one cycle
// reset clears the pipeline valid bits, hit and half_width; other payload registers are not reset
// depends on sbsh_pkg and sbsh_axis_prep
`default_nettype none

module segment_box_slab_hit_test_core
	import sbsh_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// apb configuration port
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// command channel
	input  wire                         start,
	output logic                        busy,
	input  wire  signed [COORD_BITS-1:0] start_x,
	input  wire  signed [COORD_BITS-1:0] start_z,
	input  wire  signed [COORD_BITS-1:0] end_x,
	input  wire  signed [COORD_BITS-1:0] end_z,
	input  wire  signed [COORD_BITS-1:0] box_x_min,
	input  wire  signed [COORD_BITS-1:0] box_x_max,
	input  wire  signed [COORD_BITS-1:0] box_z_min,
	input  wire  signed [COORD_BITS-1:0] box_z_max,
	// result channel
	output logic                        done,
	output logic                        hit
);

	localparam int BW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
	localparam int NW = BW + 1;
	localparam int DW = COORD_BITS;
	localparam int PW = NW + DW + 1;

	logic [HW_BITS-1:0] half_width_q;
	logic               accept;

	// axis front end outputs (after stage 2)
	logic signed [NW-1:0] x_lo, x_hi, z_lo, z_hi;
	logic        [DW-1:0] x_d, z_d;
	sbsh_axis_flags_t     x_fl, z_fl;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 3 signals
	logic signed [NW-1:0] tmin0_c, tmax0_c, tmin1_c, tmax1_c;
	logic                 take_en0_c, take_lv0_c;
	logic signed [NW-1:0] en0_n_s3, lv0_n_s3, tmin1_s3, tmax1_s3;
	logic        [DW-1:0] en0_d_s3, lv0_d_s3, d1_s3;
	logic                 mv1_s3, ok_s3;

	// stage 4 signals
	logic signed [PW-1:0] p_en_new_c, p_en_old_c, p_lv_new_c, p_lv_old_c;
	logic signed [PW-1:0] p_en_new_s4, p_en_old_s4, p_lv_new_s4, p_lv_old_s4;
	logic signed [NW-1:0] en0_n_s4, lv0_n_s4, tmin1_s4, tmax1_s4;
	logic        [DW-1:0] en0_d_s4, lv0_d_s4, d1_s4;
	logic                 mv1_s4, ok_s4;

	// stage 5 signals
	logic                 take_en1_c, take_lv1_c;
	logic signed [NW-1:0] en_n_s5, lv_n_s5;
	logic        [DW-1:0] en_d_s5, lv_d_s5;
	logic                 ok_s5;

	// stage 6 signals
	logic signed [PW-1:0] q_left_c, q_right_c;
	logic signed [PW-1:0] q_left_s6, q_right_s6;
	logic                 pos_s6, below_s6, ok_s6;

	logic                 hit_s7;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_HALF_WIDTH: half_width_q <= pwdata[HW_BITS-1:0];
				default:        half_width_q <= half_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF_WIDTH: prdata = {{(32-HW_BITS){1'b0}}, half_width_q};
			default:        prdata = '0;
		endcase
	end

	// fully pipelined, never busy
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stages 1 and 2: one front end per axis
	sbsh_axis_prep #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk        (clk),
		.seg_start  (start_x),
		.seg_end    (end_x),
		.box_min    (box_x_min),
		.box_max    (box_x_max),
		.half_width (half_width_q),
		.n_lo       (x_lo),
		.n_hi       (x_hi),
		.denom      (x_d),
		.flags      (x_fl)
	);

	sbsh_axis_prep #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk        (clk),
		.seg_start  (start_z),
		.seg_end    (end_z),
		.box_min    (box_z_min),
		.box_max    (box_z_max),
		.half_width (half_width_q),
		.n_lo       (z_lo),
		.n_hi       (z_hi),
		.denom      (z_d),
		.flags      (z_fl)
	);

	// stage 3: order the slab bounds, clip the unit interval on x
	assign tmin0_c = (x_lo < x_hi) ? x_lo : x_hi;
	assign tmax0_c = (x_lo < x_hi) ? x_hi : x_lo;
	assign tmin1_c = (z_lo < z_hi) ? z_lo : z_hi;
	assign tmax1_c = (z_lo < z_hi) ? z_hi : z_lo;
	assign take_en0_c = x_fl.moving && (tmin0_c > 0);
	assign take_lv0_c = x_fl.moving && (tmax0_c < $signed({1'b0, x_d}));

	always_ff @(posedge clk) begin
		en0_n_s3 <= take_en0_c ? tmin0_c : '0;
		en0_d_s3 <= take_en0_c ? x_d : DW'(1);
		lv0_n_s3 <= take_lv0_c ? tmax0_c : NW'(1);
		lv0_d_s3 <= take_lv0_c ? x_d : DW'(1);
		tmin1_s3 <= tmin1_c;
		tmax1_s3 <= tmax1_c;
		d1_s3    <= z_d;
		mv1_s3   <= z_fl.moving;
		ok_s3    <= (x_fl.moving || x_fl.in_slab) && (z_fl.moving || z_fl.in_slab);
	end

	// stage 4: cross products for the z slab against the x interval
	assign p_en_new_c = tmin1_s3 * $signed({1'b0, en0_d_s3});
	assign p_en_old_c = en0_n_s3 * $signed({1'b0, d1_s3});
	assign p_lv_new_c = tmax1_s3 * $signed({1'b0, lv0_d_s3});
	assign p_lv_old_c = lv0_n_s3 * $signed({1'b0, d1_s3});

	always_ff @(posedge clk) begin
		p_en_new_s4 <= p_en_new_c;
		p_en_old_s4 <= p_en_old_c;
		p_lv_new_s4 <= p_lv_new_c;
		p_lv_old_s4 <= p_lv_old_c;
		en0_n_s4    <= en0_n_s3;
		en0_d_s4    <= en0_d_s3;
		lv0_n_s4    <= lv0_n_s3;
		lv0_d_s4    <= lv0_d_s3;
		tmin1_s4    <= tmin1_s3;
		tmax1_s4    <= tmax1_s3;
		d1_s4       <= d1_s3;
		mv1_s4      <= mv1_s3;
		ok_s4       <= ok_s3;
	end

	// stage 5: clip the interval on z
	assign take_en1_c = mv1_s4 && (p_en_new_s4 > p_en_old_s4);
	assign take_lv1_c = mv1_s4 && (p_lv_new_s4 < p_lv_old_s4);

	always_ff @(posedge clk) begin
		en_n_s5 <= take_en1_c ? tmin1_s4 : en0_n_s4;
		en_d_s5 <= take_en1_c ? d1_s4 : en0_d_s4;
		lv_n_s5 <= take_lv1_c ? tmax1_s4 : lv0_n_s4;
		lv_d_s5 <= take_lv1_c ? d1_s4 : lv0_d_s4;
		ok_s5   <= ok_s4;
	end

	// stage 6: cross products for entry against exit
	assign q_left_c  = en_n_s5 * $signed({1'b0, lv_d_s5});
	assign q_right_c = lv_n_s5 * $signed({1'b0, en_d_s5});

	always_ff @(posedge clk) begin
		q_left_s6  <= q_left_c;
		q_right_s6 <= q_right_c;
		pos_s6     <= (lv_n_s5 > 0);
		below_s6   <= (en_n_s5 < $signed({1'b0, en_d_s5}));
		ok_s6      <= ok_s5;
	end

	// stage 7: final decision, held only for the strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s7 <= 1'b0;
		end else begin
			hit_s7 <= valid_s6 && ok_s6 && pos_s6 && below_s6 && (q_left_s6 <= q_right_s6);
		end
	end

	assign done = valid_s7;
	assign hit  = hit_s7;

	// every accepted beat comes out as a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("result strobe missing after accepted beat");

	// no strobe without a matching accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("result strobe without matching beat");

	// hit only shows together with the strobe
	a_hit_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit raised outside a result beat");

	// a start outside the slab on a still axis can never report a hit
	a_static_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ok_s3) |-> ##4 !hit)
		else $error("hit reported despite failed zero-extent slab");

endmodule

`default_nettype wire

// ===== sim/seg_box_hit_checker.sv =====
// result checker for segment_box_slab_hit_test_core: tracks half_width from apb writes,
// predicts hit per accepted command beat with exact fractions, compares each done beat
// depends on sbsh_pkg
`timescale 1ns / 1ps

module seg_box_hit_checker
	import sbsh_pkg::*;
#(
	parameter int CW = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	input  wire  [31:0]          prdata,
	input  wire                  pready,
	input  wire                  start,
	input  wire                  busy,
	input  wire  signed [CW-1:0] start_x,
	input  wire  signed [CW-1:0] start_z,
	input  wire  signed [CW-1:0] end_x,
	input  wire  signed [CW-1:0] end_z,
	input  wire  signed [CW-1:0] box_x_min,
	input  wire  signed [CW-1:0] box_x_max,
	input  wire  signed [CW-1:0] box_z_min,
	input  wire  signed [CW-1:0] box_z_max,
	input  wire                  done,
	input  wire                  hit,
	output int                   fail_count,
	output int                   outstanding,
	output int                   results_seen,
	output int                   hits_seen
);

	localparam logic [2:0] HW_ADDR = {REG_HALF_WIDTH, 2'b00};

	logic [HW_BITS-1:0] margin_q;
	bit                 pending_hits[$];
	int                 n_fail = 0;
	int                 n_pending = 0;
	int                 n_results = 0;
	int                 n_hits = 0;

	assign fail_count   = n_fail;
	assign outstanding  = n_pending;
	assign results_seen = n_results;
	assign hits_seen    = n_hits;

	// slab test on the widened box, every parameter an exact fraction num/den with den > 0
	function automatic bit segment_hits_box(input longint sx, sz, ex, ez, x0, x1, z0, z1,
			input longint margin);
		longint org[2], dlt[2], lo[2], hi[2];
		longint ent_n, ent_d, ext_n, ext_d, n1, n2, d, t_near, t_far;
		bit     in_slabs;
		int     k;
		org[0] = sx;
		org[1] = sz;
		dlt[0] = ex - sx;
		dlt[1] = ez - sz;
		lo[0] = x0 - margin;
		hi[0] = x1 + margin;
		lo[1] = z0 - margin;
		hi[1] = z1 + margin;
		ent_n = 0;
		ent_d = 1;
		ext_n = 1;
		ext_d = 1;
		in_slabs = 1'b1;
		for (k = 0; k < 2 && in_slabs; k++) begin
			if (dlt[k] == 0) begin
				// still axis: start must sit in the slab, bounds included
				if (org[k] < lo[k] || org[k] > hi[k])
					in_slabs = 1'b0;
			end else begin
				n1 = lo[k] - org[k];
				n2 = hi[k] - org[k];
				d = dlt[k];
				if (d < 0) begin
					n1 = -n1;
					n2 = -n2;
					d = -d;
				end
				// inverted bounds just swap near and far
				t_near = (n1 < n2) ? n1 : n2;
				t_far  = (n1 < n2) ? n2 : n1;
				if (t_near * ent_d > ent_n * d) begin
					ent_n = t_near;
					ent_d = d;
				end
				if (t_far * ext_d < ext_n * d) begin
					ext_n = t_far;
					ext_d = d;
				end
			end
		end
		return in_slabs && (ent_n * ext_d <= ext_n * ent_d) && ext_n > 0 && ent_n < ent_d;
	endfunction

	// watch config, result and command beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_hits.delete();
			margin_q <= '0;
			n_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == HW_ADDR)
				margin_q <= pwdata[HW_BITS-1:0];
			if (psel && penable && !pwrite && pready && paddr == HW_ADDR &&
					prdata[HW_BITS-1:0] !== margin_q) begin
				$error("half_width readback: expected %0d, got %0d", margin_q,
					prdata[HW_BITS-1:0]);
				n_fail++;
			end

			// result beat against the oldest prediction
			if (done) begin
				n_results++;
				if (hit === 1'b1)
					n_hits++;
				if (pending_hits.size() == 0) begin
					$error("result beat with nothing outstanding: hit %b", hit);
					n_fail++;
				end else if (hit !== pending_hits[0]) begin
					$error("hit mismatch: expected %0b, got %b", pending_hits[0], hit);
					n_fail++;
					void'(pending_hits.pop_front());
				end else begin
					void'(pending_hits.pop_front());
				end
			end

			// command beat
			if (start && !busy)
				pending_hits = {pending_hits, segment_hits_box(longint'(start_x),
					longint'(start_z), longint'(end_x), longint'(end_z),
					longint'(box_x_min), longint'(box_x_max), longint'(box_z_min),
					longint'(box_z_max), longint'(margin_q))};

			n_pending <= pending_hits.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// top of the segment versus widened box testbench: clock, reset, apb setup, segment stimulus
// depends on sbsh_pkg, segment_box_slab_hit_test_core and seg_box_hit_checker
`timescale 1ns / 1ps

module tb_top
	import sbsh_pkg::*;
();

	localparam int CW = 16;
	localparam int MAXC = (1 << (CW - 1)) - 1;
	localparam int MINC = -(1 << (CW - 1));
	localparam int RAND_PER_PHASE = 284;
	localparam int N_PHASES = 6;
	localparam logic [2:0] HW_ADDR = {REG_HALF_WIDTH, 2'b00};

	typedef struct packed {
		logic signed [CW-1:0] sx, sz, ex, ez, x0, x1, z0, z1;
	} seg_cmd_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [CW-1:0] start_x = '0;
	logic signed [CW-1:0] start_z = '0;
	logic signed [CW-1:0] end_x = '0;
	logic signed [CW-1:0] end_z = '0;
	logic signed [CW-1:0] box_x_min = '0;
	logic signed [CW-1:0] box_x_max = '0;
	logic signed [CW-1:0] box_z_min = '0;
	logic signed [CW-1:0] box_z_max = '0;
	logic                 done;
	logic                 hit;

	int fail_count, outstanding, results_seen, hits_seen;
	int n_sent = 0;
	int quiet_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_box_slab_hit_test_core #(.COORD_BITS(CW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.start_x(start_x), .start_z(start_z), .end_x(end_x), .end_z(end_z),
		.box_x_min(box_x_min), .box_x_max(box_x_max),
		.box_z_min(box_z_min), .box_z_max(box_z_max),
		.done(done), .hit(hit)
	);

	seg_box_hit_checker #(.CW(CW)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.start_x(start_x), .start_z(start_z), .end_x(end_x), .end_z(end_z),
		.box_x_min(box_x_min), .box_x_max(box_x_max),
		.box_z_min(box_z_min), .box_z_max(box_z_max),
		.done(done), .hit(hit),
		.fail_count(fail_count), .outstanding(outstanding),
		.results_seen(results_seen), .hits_seen(hits_seen)
	);

	function automatic logic signed [CW-1:0] sat_coord(input int v);
		if (v > MAXC)
			v = MAXC;
		else if (v < MINC)
			v = MINC;
		return v[CW-1:0];
	endfunction

	function automatic seg_cmd_t mk(input int sx, sz, ex, ez, x0, x1, z0, z1);
		seg_cmd_t c;
		c.sx = sx[CW-1:0];
		c.sz = sz[CW-1:0];
		c.ex = ex[CW-1:0];
		c.ez = ez[CW-1:0];
		c.x0 = x0[CW-1:0];
		c.x1 = x1[CW-1:0];
		c.z0 = z0[CW-1:0];
		c.z1 = z1[CW-1:0];
		return c;
	endfunction

	// mostly a box with a segment near it; some noise, inverted, still and touching cases
	function automatic seg_cmd_t random_segment(input int margin);
		seg_cmd_t c;
		int       r, cx, cz, wx, wz, reach, corner;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			c = {$urandom, $urandom, $urandom, $urandom};
			return c;
		end
		cx = int'($urandom_range(0, (1 << CW) - 1)) + MINC;
		cz = int'($urandom_range(0, (1 << CW) - 1)) + MINC;
		wx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 1 << $urandom_range(0, 8))
			: $urandom_range(0, 1 << $urandom_range(9, 15));
		wz = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 1 << $urandom_range(0, 8))
			: $urandom_range(0, 1 << $urandom_range(9, 15));
		c.x0 = sat_coord(cx - wx);
		c.x1 = sat_coord(cx + wx);
		c.z0 = sat_coord(cz - wz);
		c.z1 = sat_coord(cz + wz);
		if (r < 20) begin
			if ($urandom_range(0, 1))
				{c.x0, c.x1} = {c.x1, c.x0};
			else
				{c.z0, c.z1} = {c.z1, c.z0};
		end
		reach = 2 * ((wx > wz) ? wx : wz) + 2 * margin + 4;
		c.sx = sat_coord(cx + int'($urandom_range(0, 2 * reach)) - reach);
		c.sz = sat_coord(cz + int'($urandom_range(0, 2 * reach)) - reach);
		c.ex = sat_coord(cx + int'($urandom_range(0, 2 * reach)) - reach);
		c.ez = sat_coord(cz + int'($urandom_range(0, 2 * reach)) - reach);
		if (r >= 20 && r < 35) begin
			// still on one or both axes
			c.ex = c.sx;
			if ($urandom_range(0, 1))
				c.ez = c.sz;
		end else if (r >= 35 && r < 50) begin
			// endpoints or a whole edge exactly on a widened bound
			corner = $urandom_range(0, 3);
			case (corner)
				0: c.ex = sat_coord(c.x0 - margin);
				1: c.sx = sat_coord(c.x1 + margin);
				2: begin
					c.sz = sat_coord(c.z1 + margin);
					c.ez = c.sz;
				end
				default: begin
					c.sx = sat_coord(c.x0 - margin);
					c.sz = sat_coord(c.z0 - margin);
				end
			endcase
		end
		return c;
	endfunction

	// one command beat, then a random gap; quiet stretches keep start high
	task automatic send_segment(input seg_cmd_t c);
		int r, gap;
		start <= 1'b1;
		start_x <= c.sx;
		start_z <= c.sz;
		end_x <= c.ex;
		end_z <= c.ez;
		box_x_min <= c.x0;
		box_x_max <= c.x1;
		box_z_min <= c.z0;
		box_z_max <= c.z1;
		do @(posedge clk); while (busy);
		n_sent++;
		gap = 0;
		if (quiet_left > 0) begin
			quiet_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				quiet_left = $urandom_range(20, 80);
			if (r >= 50)
				gap = (r < 85) ? $urandom_range(1, 3) : (r < 97) ? $urandom_range(4, 12)
					: $urandom_range(20, 60);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off commands until every predicted result is back
	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// setup and access cycle, then return to idle
	task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		seg_cmd_t    directed_q[$];
		logic [31:0] setting;
		int          margin;
		int          phase;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed segments against the reset half_width of zero
		directed_q = {directed_q, mk(-100, 0, 100, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-100, 50, 100, 50, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-100, 0, -10, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(10, 0, 100, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-100, 10, 100, 10, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(0, 0, 0, 0, 10, -10, -10, 10)};
		directed_q = {directed_q, mk(-100, 0, 100, 0, 10, -10, -10, 10)};
		directed_q = {directed_q, mk(0, 0, 0, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(50, 0, 50, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(10, 10, 10, 10, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-20, 0, 0, 20, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-21, 0, 0, 21, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(MINC, MINC, MAXC, MAXC, MINC, MAXC, MINC, MAXC)};
		directed_q = {directed_q, mk(MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC)};
		directed_q = {directed_q, mk(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC)};
		directed_q = {directed_q, mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC)};
		directed_q = {directed_q, mk('h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 'hAAAA,
			'hAAAA, 'h5555)};
		directed_q = {directed_q, mk(100, 0, -100, 0, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(100, 100, -100, -100, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-5, -5, 5, 5, -10, 10, -10, 10)};
		directed_q = {directed_q, mk(-100, 0, 100, 0, -10, 10, 20, 30)};
		foreach (directed_q[i])
			send_segment(directed_q[i]);

		// random segments under several half_width settings
		for (phase = 0; phase < N_PHASES; phase++) begin
			wait_all_results();
			case (phase)
				0: setting = 32'hFFFF_FFFF;
				1: setting = 32'h0;
				2: setting = $urandom;
				3: setting = 32'h1;
				4: setting = 32'h0000_0FFF;
				default: setting = {8'($urandom_range(0, 255)), 24'h0}
					| 32'($urandom_range(0, 64));
			endcase
			apb_xfer(1'b1, HW_ADDR, setting);
			apb_xfer(1'b0, HW_ADDR, '0);
			margin = int'(setting[HW_BITS-1:0]);
			repeat (RAND_PER_PHASE)
				send_segment(random_segment(margin));
		end

		wait_all_results();
		repeat (20) @(posedge clk);

		$display("tb_top: %0d segments sent under half_width 0, 1, 4095 and random values",
			n_sent);
		$display("tb_top: %0d results compared, %0d of them hits", results_seen, hits_seen);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
